[rtl/fva_pkg.sv]
// ----------------------------------------------------------------------------
// fva_pkg: shared types and constants of the FM voice allocator
// Command and result codes, stream widths, and the control and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fva_pkg;

	// Default number of voice slots.
	localparam int MAX_VOICES_DEF = 18;

	// Field widths of one input item and one result item.
	localparam int CMD_W    = 2;
	localparam int FLAGS_W  = 2;
	localparam int VOICE_W  = 5;
	localparam int TIME_W   = 32;
	localparam int KIND_W   = 2;
	localparam int ACTIVE_W = 5;

	// Packed stream widths, rounded up to whole bytes.
	localparam int IN_BITS  = CMD_W + FLAGS_W + 1 + VOICE_W + TIME_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = VOICE_W + 1 + KIND_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// Reset value of the active voice count.
	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd9;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TOUCH   = 2'd2;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_FREE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_OLDEST = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              load;       // latch the request, set the scan start
		logic              step;       // advance the scan index and counter
		logic              track;      // fold the current voice into the oldest search
		logic              pick;       // record the current voice as the result
		logic              pick_old;   // record the oldest voice as the result
		logic [KIND_W-1:0] kind;       // kind recorded with a pick
		logic              ptr_set;    // search pointer takes the current voice
		logic              steal_init; // restart the scan at voice 0 for stealing
		logic              commit;     // update voice state and load the result
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic               in_alloc; // offered item is an allocate request
		logic [FLAGS_W-1:0] flags;    // search flags of the latched request
		logic               hit_free; // current voice is free
		logic               hit_sec;  // current voice is marked secondary
		logic               last;     // current voice is the last of the scan
		logic               have_old; // an older voice has been seen, this one included
		logic               out_room; // the output register can take a result
	} sts_t;

endpackage

[rtl/fva_ctrl.sv]
// ----------------------------------------------------------------------------
// fva_ctrl: allocator controller
// Sequences one item at a time through the free scan and the steal scan of an
// allocate and the final state update, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module fva_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  fva_pkg::sts_t sts,
	output fva_pkg::ctl_t ctl
);
	import fva_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FREE  = 2'd1;
	localparam logic [1:0] ST_STEAL = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.load = 1'b1;
					state_d  = sts.in_alloc ? ST_FREE : ST_DONE;
				end
			end
			ST_FREE: begin
				if (sts.hit_free) begin
					ctl.pick    = 1'b1;
					ctl.kind    = KIND_FREE;
					ctl.ptr_set = 1'b1;
					state_d     = ST_DONE;
				end else if (sts.last) begin
					// No free voice: the pointer rests on the last voice looked at.
					ctl.ptr_set = 1'b1;
					if (sts.flags[0]) begin
						state_d = ST_DONE;
					end else begin
						ctl.steal_init = 1'b1;
						state_d        = ST_STEAL;
					end
				end else begin
					ctl.step = 1'b1;
				end
			end
			ST_STEAL: begin
				if (sts.hit_sec) begin
					ctl.pick = 1'b1;
					ctl.kind = KIND_SECOND;
					state_d  = ST_DONE;
				end else begin
					ctl.track = 1'b1;
					if (sts.last) begin
						if (!sts.flags[1] && sts.have_old) begin
							ctl.pick_old = 1'b1;
							ctl.kind     = KIND_OLDEST;
						end
						state_d = ST_DONE;
					end else begin
						ctl.step = 1'b1;
					end
				end
			end
			ST_DONE: begin
				if (sts.out_room) begin
					ctl.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/fva_datapath.sv]
// ----------------------------------------------------------------------------
// fva_datapath: allocator voice state and scan datapath
// Holds the per-voice free, secondary and start time state, the search
// pointer, the scan index, the oldest-voice tracker and the output register.
// ----------------------------------------------------------------------------
module fva_datapath #(
	parameter int MAX_VOICES = fva_pkg::MAX_VOICES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [fva_pkg::IN_W-1:0]     s_tdata,
	input  logic                         cfg_we,
	input  logic [fva_pkg::ACTIVE_W-1:0] cfg_wdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [fva_pkg::OUT_W-1:0]    m_tdata,
	input  fva_pkg::ctl_t                ctl,
	output fva_pkg::sts_t                sts
);
	import fva_pkg::*;

	localparam int VW = $clog2(MAX_VOICES);
	localparam int NW = $clog2(MAX_VOICES + 1);

	// Voice state.
	logic [MAX_VOICES-1:0] free_q;
	logic [MAX_VOICES-1:0] sec_q;
	logic [TIME_W-1:0]     time_q [MAX_VOICES];
	logic [VW-1:0]         ptr_q;
	logic                  ptr_vld_q;
	logic [ACTIVE_W-1:0]   active_q;

	// Latched request.
	logic [CMD_W-1:0]   cmd_q;
	logic [FLAGS_W-1:0] flags_q;
	logic               mark_q;
	logic [VOICE_W-1:0] target_q;
	logic [TIME_W-1:0]  now_q;

	// Scan and result registers.
	logic [VW-1:0]     idx_q;
	logic [VW-1:0]     cnt_q;
	logic [TIME_W-1:0] old_time_q;
	logic [VW-1:0]     old_idx_q;
	logic              have_old_q;
	logic [VW-1:0]     res_voice_q;
	logic              res_found_q;
	logic [KIND_W-1:0] res_kind_q;
	logic              out_vld_q;
	logic [OUT_W-1:0]  out_data_q;

	logic [NW-1:0] n_eff;
	logic [NW-1:0] ptr_plus;
	logic [VW-1:0] start_idx;
	logic [NW-1:0] idx_plus;
	logic [VW-1:0] idx_next;
	logic          older;
	logic          have_old_nxt;
	logic [VW-1:0] old_idx_nxt;
	logic          tgt_ok;
	logic          out_room;

	// Effective voice count: zero acts as one, large values clamp.
	always_comb begin
		if (active_q == '0) begin
			n_eff = NW'(1);
		end else if (int'(active_q) > MAX_VOICES) begin
			n_eff = NW'(MAX_VOICES);
		end else begin
			n_eff = NW'(active_q);
		end
	end

	// Scan start and cyclic advance.
	assign ptr_plus  = NW'(ptr_q) + NW'(1);
	assign start_idx = (ptr_vld_q && (ptr_plus < n_eff)) ? VW'(ptr_plus) : '0;
	assign idx_plus  = NW'(idx_q) + NW'(1);
	assign idx_next  = (idx_plus == n_eff) ? '0 : VW'(idx_plus);

	// Oldest-voice comparison for the current voice.
	assign older        = time_q[idx_q] < old_time_q;
	assign have_old_nxt = have_old_q | older;
	assign old_idx_nxt  = older ? idx_q : old_idx_q;

	assign tgt_ok   = int'(target_q) < MAX_VOICES;
	assign out_room = !out_vld_q || m_tready;

	// Status to the controller.
	always_comb begin
		sts          = '0;
		sts.in_alloc = s_tdata[CMD_W-1:0] == CMD_ALLOC;
		sts.flags    = flags_q;
		sts.hit_free = free_q[idx_q];
		sts.hit_sec  = sec_q[idx_q];
		sts.last     = NW'(cnt_q) == (n_eff - NW'(1));
		sts.have_old = have_old_nxt;
		sts.out_room = out_room;
	end

	// Request latch; payload needs no reset.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= s_tdata[1:0];
			flags_q  <= s_tdata[3:2];
			mark_q   <= s_tdata[4];
			target_q <= s_tdata[9:5];
			now_q    <= s_tdata[41:10];
		end
	end

	// Scan index, counter, oldest tracker and result.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			idx_q       <= start_idx;
			cnt_q       <= '0;
			res_voice_q <= '0;
			res_found_q <= 1'b0;
			res_kind_q  <= KIND_FREE;
		end else if (ctl.steal_init) begin
			idx_q      <= '0;
			cnt_q      <= '0;
			old_time_q <= now_q;
			old_idx_q  <= '0;
			have_old_q <= 1'b0;
		end else begin
			if (ctl.step) begin
				idx_q <= idx_next;
				cnt_q <= cnt_q + VW'(1);
			end
			if (ctl.track && older) begin
				old_time_q <= time_q[idx_q];
				old_idx_q  <= idx_q;
				have_old_q <= 1'b1;
			end
			if (ctl.pick) begin
				res_voice_q <= idx_q;
				res_found_q <= 1'b1;
				res_kind_q  <= ctl.kind;
			end else if (ctl.pick_old) begin
				res_voice_q <= old_idx_nxt;
				res_found_q <= 1'b1;
				res_kind_q  <= ctl.kind;
			end
		end
	end

	// Active voice count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	// Search pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			ptr_vld_q <= 1'b0;
		end else if (ctl.ptr_set) begin
			ptr_q     <= idx_q;
			ptr_vld_q <= 1'b1;
		end
	end

	// Voice state update at commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
			sec_q  <= '1;
			for (int i = 0; i < MAX_VOICES; i++) begin
				time_q[i] <= '1;
			end
		end else if (ctl.commit) begin
			case (cmd_q)
				CMD_ALLOC: begin
					if (res_found_q) begin
						free_q[res_voice_q] <= 1'b0;
						sec_q[res_voice_q]  <= mark_q;
						time_q[res_voice_q] <= now_q;
					end
				end
				CMD_RELEASE: begin
					if (tgt_ok) begin
						free_q[target_q[VW-1:0]] <= 1'b1;
						sec_q[target_q[VW-1:0]]  <= 1'b0;
					end
				end
				CMD_TOUCH: begin
					if (tgt_ok) begin
						time_q[target_q[VW-1:0]] <= now_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: chosen_voice, found, stolen_kind from bit 0 up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.commit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			out_data_q <= OUT_W'({res_kind_q, res_found_q, VOICE_W'(res_voice_q)});
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

[rtl/fm_voice_allocator.sv]
// ----------------------------------------------------------------------------
// fm_voice_allocator: voice allocator for an FM synthesizer
// Next-fit free voice search with secondary and oldest voice stealing.
// ----------------------------------------------------------------------------
// Usage: commands arrive as items on the s_ stream and each produces exactly
// one result item on the m_ stream. An allocate scans the active voices one
// per cycle from the voice after the search pointer; if none is free and
// search_flags[0] is clear it scans again from voice 0 for a secondary or,
// unless search_flags[1] is set, the oldest voice. Release and touch update
// one voice. The active voice count is written through cfg_we and cfg_wdata
// while the block is idle. The scan loop looks at one voice per cycle, and
// one item is in work at a time.
// Reset clears all voices to free and secondary with start time all ones,
// the count to 9 and the search pointer to before voice 0.
// When the receiver stalls, the result waits in the output register; the
// block still accepts and works the next item, and holds its result until
// the output register is taken.
// ----------------------------------------------------------------------------
module fm_voice_allocator #(
	parameter int MAX_VOICES = fva_pkg::MAX_VOICES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// cmd[1:0], search_flags[3:2], mark_secondary[4], target_voice[9:5],
	// now[41:10], zero[47:42]
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [fva_pkg::IN_W-1:0]     s_tdata,
	// chosen_voice[4:0], found[5], stolen_kind[7:6]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [fva_pkg::OUT_W-1:0]    m_tdata,
	input  logic                         cfg_we,
	input  logic [fva_pkg::ACTIVE_W-1:0] cfg_wdata
);
	import fva_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// Sequencer.
	fva_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// Voice state and scan datapath.
	fva_datapath #(
		.MAX_VOICES (MAX_VOICES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.ctl       (ctl),
		.sts       (sts)
	);

endmodule

[rtl/fva_checker.sv]
// ----------------------------------------------------------------------------
// fva_checker: port-level checks for the FM voice allocator
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module fva_checker #(
	parameter int MAX_VOICES = fva_pkg::MAX_VOICES_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [fva_pkg::OUT_W-1:0] m_tdata
);
	import fva_pkg::*;

	// Only one item is in work: the input closes right after an accept.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in work");

	// A result without a voice carries all-zero fields.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[5] |-> (m_tdata[4:0] == '0) && (m_tdata[7:6] == KIND_FREE))
		else $error("result without a voice has nonzero fields");

	// An allocated voice lies within the voice slots and has a known kind.
	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[5] |-> (int'(m_tdata[4:0]) < MAX_VOICES)
			&& (m_tdata[7:6] != 2'd3))
		else $error("allocated voice or kind out of range");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind fm_voice_allocator fva_checker #(
	.MAX_VOICES (MAX_VOICES)
) u_fva_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[tb/sv/fm_voice_allocator_tb.sv]
// ----------------------------------------------------------------------------
// fm_voice_allocator_tb: self-checking testbench of the FM voice allocator
// Sends allocate, release, touch and unused commands on the input stream,
// predicts every result from a private copy of the voice table, and compares
// each result item field by field. Covers several active voice counts, with
// random idling on both stream sides.
// ----------------------------------------------------------------------------
module fm_voice_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fva_pkg::*;

	localparam int                 VOICES     = MAX_VOICES_DEF;
	localparam logic [CMD_W-1:0]   CMD_UNUSED = 2'd3;
	localparam logic [FLAGS_W-1:0] FLAG_STOP  = 2'd1;
	localparam logic [FLAGS_W-1:0] FLAG_KEEP  = 2'd2;
	localparam int                 STALL_MAX  = 4000;

	// Input item as packed on s_tdata, lowest field in the lowest bits.
	typedef struct packed {
		logic [IN_W-IN_BITS-1:0] pad;
		logic [TIME_W-1:0]       now;
		logic [VOICE_W-1:0]      target;
		logic                    sec;
		logic [FLAGS_W-1:0]      flags;
		logic [CMD_W-1:0]        cmd;
	} voice_cmd_t;

	// Result item as packed on m_tdata.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic               found;
		logic [VOICE_W-1:0] voice;
	} voice_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;
	logic                cfg_we = 1'b0;
	logic [ACTIVE_W-1:0] cfg_wdata = '0;

	// Private copy of the voice table and the search pointer.
	bit                voice_idle [VOICES];
	bit                voice_second [VOICES];
	bit [TIME_W-1:0]   voice_stamp [VOICES];
	int                scan_ptr;
	bit                scan_ptr_ok;
	bit [ACTIVE_W-1:0] active_cfg;

	voice_result_t alloc_expect_q[$];
	voice_result_t got, want;
	int            errors;
	int            cmds_sent;
	int            results_seen;
	int            kind_count [3];
	int            misses;
	int            send_idle_pct;
	int            recv_idle_pct;
	int            stall_cycles;
	bit [TIME_W-1:0] stamp_clock;

	fm_voice_allocator #(
		.MAX_VOICES(VOICES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Free-running clock.
	initial begin
		forever #4 clk = ~clk;
	end

	// Effective voice count: zero acts as one, large values clamp to the table.
	function automatic int usable_voices();
		int n;
		n = int'(active_cfg);
		if (n < 1) n = 1;
		if (n > VOICES) n = VOICES;
		return n;
	endfunction

	// Mark one voice busy with the request's secondary mark and time.
	function automatic void claim_voice(int v, bit sec, bit [TIME_W-1:0] now);
		voice_idle[v]   = 1'b0;
		voice_second[v] = sec;
		voice_stamp[v]  = now;
	endfunction

	// Apply one command to the voice table and return the result it yields.
	function automatic voice_result_t allocate_or_update(voice_cmd_t c);
		voice_result_t   r;
		int              n;
		int              start;
		int              v;
		int              oldest;
		bit              done;
		bit              have_old;
		bit [TIME_W-1:0] oldtime;
		r = '0;
		case (c.cmd)
			CMD_ALLOC: begin
				n = usable_voices();
				start = (scan_ptr_ok && scan_ptr + 1 < n) ? scan_ptr + 1 : 0;
				done = 1'b0;
				// Next-fit search for a free voice.
				for (int i = 0; i < n && !done; i++) begin
					v = (start + i) % n;
					if (voice_idle[v]) begin
						scan_ptr = v;
						scan_ptr_ok = 1'b1;
						claim_voice(v, c.sec, c.now);
						r = '{kind: KIND_FREE, found: 1'b1, voice: v[VOICE_W-1:0]};
						done = 1'b1;
					end
				end
				if (!done) begin
					scan_ptr = (start + n - 1) % n;
					scan_ptr_ok = 1'b1;
					if ((c.flags & FLAG_STOP) == '0) begin
						// Steal the first secondary voice, else track the oldest one.
						have_old = 1'b0;
						oldest = 0;
						oldtime = c.now;
						for (int i = 0; i < n && !done; i++) begin
							if (voice_second[i]) begin
								claim_voice(i, c.sec, c.now);
								r = '{kind: KIND_SECOND, found: 1'b1, voice: i[VOICE_W-1:0]};
								done = 1'b1;
							end else if (voice_stamp[i] < oldtime) begin
								oldtime = voice_stamp[i];
								oldest = i;
								have_old = 1'b1;
							end
						end
						if (!done && (c.flags & FLAG_KEEP) == '0 && have_old) begin
							claim_voice(oldest, c.sec, c.now);
							r = '{kind: KIND_OLDEST, found: 1'b1, voice: oldest[VOICE_W-1:0]};
						end
					end
				end
			end
			CMD_RELEASE: begin
				if (c.target < VOICES) begin
					voice_idle[c.target]   = 1'b1;
					voice_second[c.target] = 1'b0;
				end
			end
			CMD_TOUCH: begin
				if (c.target < VOICES) voice_stamp[c.target] = c.now;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Send one command item and record the result it should produce.
	task automatic send_command(logic [CMD_W-1:0] cmd, logic [FLAGS_W-1:0] flags,
			logic sec, logic [VOICE_W-1:0] target, logic [TIME_W-1:0] now);
		voice_cmd_t c;
		c = '{pad: '0, now: now, target: target, sec: sec, flags: flags, cmd: cmd};
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		do @(posedge clk); while (!s_tready);
		alloc_expect_q.push_back(allocate_or_update(c));
		cmds_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Lower valid and wait until every expected result has been taken.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (alloc_expect_q.size() != 0) @(posedge clk);
	endtask

	// Write the active voice count while the block is idle.
	task automatic write_active_count(logic [ACTIVE_W-1:0] value);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		active_cfg = value;
		cfg_we <= 1'b0;
	endtask

	// Reset state, default count, all special cases of the search on two voices.
	task automatic test_directed_cases();
		send_command(CMD_ALLOC, 2'd0, 1'b1, 5'd0, 32'd1);
		write_active_count(5'd2);
		send_command(CMD_ALLOC, 2'd0, 1'b1, 5'd0, 32'd10);
		send_command(CMD_ALLOC, 2'd0, 1'b0, 5'd0, 32'd20);
		send_command(CMD_ALLOC, FLAG_STOP, 1'b0, 5'd0, 32'd25);
		send_command(CMD_ALLOC, 2'd0, 1'b0, 5'd0, 32'd30);
		send_command(CMD_ALLOC, FLAG_KEEP, 1'b0, 5'd0, 32'd40);
		send_command(CMD_ALLOC, 2'd0, 1'b0, 5'd0, 32'd40);
		// No voice is strictly older than time zero.
		send_command(CMD_ALLOC, 2'd0, 1'b0, 5'd0, 32'd0);
		send_command(CMD_TOUCH, 2'd0, 1'b0, 5'd0, 32'd5);
		send_command(CMD_TOUCH, 2'd3, 1'b1, 5'd1, 32'd5);
		send_command(CMD_ALLOC, 2'd0, 1'b1, 5'd0, 32'd5);
		// Equal ages go to the lowest index.
		send_command(CMD_ALLOC, 2'd0, 1'b0, 5'd0, 32'd6);
		send_command(CMD_RELEASE, 2'd0, 1'b0, 5'd1, 32'd0);
		send_command(CMD_RELEASE, 2'd3, 1'b1, 5'd31, 32'hFFFF_FFFF);
		send_command(CMD_TOUCH, 2'd0, 1'b0, 5'd18, 32'hFFFF_FFFF);
		send_command(CMD_UNUSED, 2'd3, 1'b1, 5'd17, 32'hA5A5_5A5A);
		send_command(CMD_ALLOC, 2'd3, 1'b1, 5'd31, 32'hFFFF_FFFF);
	endtask

	// Count zero acts as one voice, counts above the table act as all voices.
	task automatic test_active_extremes();
		write_active_count(5'd0);
		send_command(CMD_ALLOC, 2'd0, 1'b0, 5'd0, 32'd100);
		send_command(CMD_ALLOC, 2'd0, 1'b0, 5'd0, 32'd101);
		write_active_count(5'd31);
		send_command(CMD_ALLOC, 2'd0, 1'b0, 5'd0, 32'd200);
		send_command(CMD_TOUCH, 2'd0, 1'b0, 5'd17, 32'd201);
		send_command(CMD_RELEASE, 2'd0, 1'b0, 5'd17, 32'd202);
		send_command(CMD_ALLOC, 2'd0, 1'b1, 5'd0, 32'd203);
	endtask

	// Random traffic: mostly allocations so the table fills and steals happen.
	task automatic run_traffic_segment(int count, logic [ACTIVE_W-1:0] active);
		int                 pick;
		logic [CMD_W-1:0]   cmd;
		logic [VOICE_W-1:0] target;
		write_active_count(active);
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 55) cmd = CMD_ALLOC;
			else if (pick < 77) cmd = CMD_RELEASE;
			else if (pick < 95) cmd = CMD_TOUCH;
			else cmd = CMD_UNUSED;
			if ($urandom_range(99) < 85) begin
				target = VOICE_W'($urandom_range(usable_voices() - 1));
			end else begin
				target = VOICE_W'($urandom_range(31));
			end
			// Time mostly creeps forward; sometimes it stands or jumps anywhere.
			pick = $urandom_range(99);
			if (pick < 70) stamp_clock += $urandom_range(1, 3);
			else if (pick < 95 && pick >= 85) stamp_clock = $urandom;
			else if (pick >= 95) stamp_clock = pick[0] ? '1 : '0;
			send_command(cmd, FLAGS_W'($urandom_range(3)), $urandom_range(99) < 25,
				target, stamp_clock);
		end
	endtask

	task automatic test_random_traffic();
		send_idle_pct = 22;
		recv_idle_pct = 88;
		run_traffic_segment(125, 5'd9);
		run_traffic_segment(125, 5'd18);
		send_idle_pct = 88;
		recv_idle_pct = 22;
		run_traffic_segment(125, 5'd31);
		run_traffic_segment(125, 5'd1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_traffic_segment(125, 5'd0);
		run_traffic_segment(125, ACTIVE_W'($urandom_range(2, 17)));
	endtask

	// Receiver ready with random stalls.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Compare every result item with the oldest expectation.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			results_seen++;
			if (got.found) kind_count[got.kind % 3]++;
			else misses++;
			if (alloc_expect_q.size() == 0) begin
				$display("%0t: unexpected result item %h", $time, got);
				errors++;
			end else begin
				want = alloc_expect_q.pop_front();
				if (got.voice !== want.voice) begin
					$display("%0t: chosen_voice expected %0d actual %0d", $time,
						want.voice, got.voice);
					errors++;
				end
				if (got.found !== want.found) begin
					$display("%0t: found expected %0d actual %0d", $time,
						want.found, got.found);
					errors++;
				end
				if (got.kind !== want.kind) begin
					$display("%0t: stolen_kind expected %0d actual %0d", $time,
						want.kind, got.kind);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles in which no item moves on either stream.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_MAX) begin
			$display("%0t: no item moved for %0d cycles", $time, STALL_MAX);
			$display("status: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Test sequence; the counters start at zero.
	initial begin
		for (int i = 0; i < VOICES; i++) begin
			voice_idle[i]   = 1'b1;
			voice_second[i] = 1'b1;
			voice_stamp[i]  = '1;
		end
		scan_ptr      = 0;
		scan_ptr_ok   = 1'b0;
		active_cfg    = ACTIVE_RESET;
		cmds_sent     = 0;
		stamp_clock   = 32'd1000;
		send_idle_pct = 22;
		recv_idle_pct = 88;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_active_extremes();
		test_random_traffic();

		drain_results();
		repeat (40) @(posedge clk);
		$display("Sent %0d commands over active counts 0, 1, 2, 9, 18, 31 and one random.",
			cmds_sent);
		$display("Results %0d: %0d free, %0d secondary steals, %0d oldest steals, %0d none.",
			results_seen, kind_count[0], kind_count[1], kind_count[2], misses);
		if (errors == 0 && alloc_expect_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[files.f]
rtl/fva_pkg.sv
rtl/fva_ctrl.sv
rtl/fva_datapath.sv
rtl/fm_voice_allocator.sv
rtl/fva_checker.sv
tb/sv/fm_voice_allocator_tb.sv
